### rtl/lcgrb_pkg.sv
// ----------------------------------------------------------------------------
// lcgrb_pkg: shared types and constants for the LCG random byte source
// Beat layouts for both channels and the fixed generator/finalizer constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgrb_pkg;

  // Command codes on the request channel
  localparam logic CmdRead = 1'b0;
  localparam logic CmdSeed = 1'b1;

  // LCG step: state = LcgMul * state + LcgAdd (mod 2^64)
  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  localparam logic [63:0] LcgAdd = 64'd1442695040888963407;

  // fmix64 finalizer constants
  localparam logic [63:0] FmixK1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixK2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FmixShift = 33;

  // Reset value of the initial seed register
  localparam logic [63:0] SeedReset = 64'hDEADBEEFCAFEBABE;

  // Request beat
  typedef struct packed {
    logic        command;
    logic [63:0] seed_value;
    logic [6:0]  read_length;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] random_byte;
    logic       last_byte;
  } out_t;

endpackage

`default_nettype wire

### rtl/lcg_mixed_random_byte_source.sv
// ----------------------------------------------------------------------------
// lcg_mixed_random_byte_source: random byte source (64-bit LCG + fmix64)
// Seed writes load the generator; reads return N bytes, one per result beat,
// from 32-bit words made by an LCG step followed by the fmix64 finalizer.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | beat
//  ---------+-----------+---------------------+------------------------------
//  request  | in        | in_valid/in_ready   | command, seed_value, read_len
//  result   | out       | out_valid/out_ready | random_byte, last_byte
//  config   | in        | cfg_we (no wait)    | power-on seed (64 bit)
//
// A seed write or zero-length read is done when it is accepted. Each 32-bit
// word takes three 64x64 low-half multiplies, each built from three passes
// through one shared 32x32 multiplier plus a finishing step. Each byte is
// then loaded into the output register. A stalled result holds the byte
// stream; the next word is generated while the fourth byte of a word waits
// in the output register.
// Reset clears the generator state and seeded flag; no clearing pass.

`default_nettype none

module lcg_mixed_random_byte_source #(
  parameter int unsigned MAX_READ_BYTES = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // request channel
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire lcgrb_pkg::in_t  in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output lcgrb_pkg::out_t      out_data_o,
  // configuration
  input  wire                  cfg_we_i,
  input  wire [63:0]           cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_READ_BYTES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_LCG,
    OP_K1,
    OP_K2
  } op_e;

  state_e          state_q;
  op_e             op_q;
  logic [1:0]      phase_q;
  logic [63:0]     seed_cfg_q;
  logic [63:0]     gen_q;
  logic            seeded_q;
  logic [63:0]     x_q;
  logic [63:0]     acc_q;
  logic [63:0]     acc_d;
  logic [31:0]     word_q;
  logic [CntW-1:0] left_q;
  logic [1:0]      byte_q;
  logic            out_valid_q;
  lcgrb_pkg::out_t out_q;

  logic [63:0]     mul_k;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [63:0]     prod;
  logic [63:0]     lcg_next;
  logic [63:0]     fmix_x;
  logic [CntW-1:0] len_sat;
  logic            in_beat;
  logic            out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Saturate the requested length
  always_comb begin
    if (in_data_i.read_length > 7'(MAX_READ_BYTES)) begin
      len_sat = CntW'(MAX_READ_BYTES);
    end else begin
      len_sat = in_data_i.read_length[CntW-1:0];
    end
  end

  // Constant operand for the current multiply
  always_comb begin
    unique case (op_q)
      OP_LCG:  mul_k = lcgrb_pkg::LcgMul;
      OP_K1:   mul_k = lcgrb_pkg::FmixK1;
      OP_K2:   mul_k = lcgrb_pkg::FmixK2;
      default: mul_k = lcgrb_pkg::FmixK2;
    endcase
  end

  // Shared 32x32 multiplier; low 64 bits of x*k over three passes:
  // xL*kL, then xL*kH and xH*kL added into the upper half
  assign mul_a = (phase_q == 2'd2) ? x_q[63:32] : x_q[31:0];
  assign mul_b = (phase_q == 2'd1) ? mul_k[63:32] : mul_k[31:0];
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    if (phase_q == 2'd0) begin
      acc_d = prod;
    end else begin
      acc_d = acc_q + {prod[31:0], 32'd0};
    end
  end

  // Post-multiply steps
  assign lcg_next = acc_q + lcgrb_pkg::LcgAdd;
  assign fmix_x   = acc_q ^ (acc_q >> lcgrb_pkg::FmixShift);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_cfg_q <= lcgrb_pkg::SeedReset;
    end else if (cfg_we_i) begin
      seed_cfg_q <= cfg_wdata_i;
    end
  end

  // Sequencer, generator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_LCG;
      phase_q     <= 2'd0;
      gen_q       <= 64'd0;
      seeded_q    <= 1'b0;
      x_q         <= 64'd0;
      acc_q       <= 64'd0;
      word_q      <= 32'd0;
      left_q      <= '0;
      byte_q      <= 2'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // in ST_EMIT a taken beat is always replaced by the next byte below
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_data_i.command == lcgrb_pkg::CmdSeed) begin
              gen_q    <= in_data_i.seed_value;
              seeded_q <= 1'b1;
            end else if (len_sat != '0) begin
              // first read seeds from the config register if needed
              if (!seeded_q) begin
                gen_q    <= seed_cfg_q;
                x_q      <= seed_cfg_q;
                seeded_q <= 1'b1;
              end else begin
                x_q <= gen_q;
              end
              left_q  <= len_sat;
              byte_q  <= 2'd0;
              op_q    <= OP_LCG;
              phase_q <= 2'd0;
              state_q <= ST_MUL;
            end
          end
        end

        ST_MUL: begin
          acc_q <= acc_d;
          if (phase_q == 2'd2) begin
            phase_q <= 2'd0;
            state_q <= ST_FIN;
          end else begin
            phase_q <= phase_q + 2'd1;
          end
        end

        ST_FIN: begin
          unique case (op_q)
            OP_LCG: begin
              gen_q   <= lcg_next;
              x_q     <= lcg_next ^ (lcg_next >> lcgrb_pkg::FmixShift);
              op_q    <= OP_K1;
              state_q <= ST_MUL;
            end
            OP_K1: begin
              x_q     <= fmix_x;
              op_q    <= OP_K2;
              state_q <= ST_MUL;
            end
            default: begin
              word_q  <= fmix_x[63:32];
              state_q <= ST_EMIT;
            end
          endcase
        end

        ST_EMIT: begin
          // one byte per beat, least significant first
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.random_byte <= word_q[7:0];
            out_q.last_byte   <= (left_q == CntW'(1));
            word_q            <= word_q >> 8;
            left_q            <= left_q - CntW'(1);
            byte_q            <= byte_q + 2'd1;
            if (left_q == CntW'(1)) begin
              state_q <= ST_IDLE;
            end else if (byte_q == 2'd3) begin
              x_q     <= gen_q;
              op_q    <= OP_LCG;
              phase_q <= 2'd0;
              state_q <= ST_MUL;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### bench/tb_lcg_mixed_random_byte_source.sv
// ----------------------------------------------------------------------------
// tb_lcg_mixed_random_byte_source: self-checking bench for the LCG byte source
// Drives seed writes and reads of random length through the request channel
// and predicts every byte from a local LCG plus fmix64 model. Each result beat
// is checked against the oldest predicted byte. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

// Predicts the byte stream and holds the bytes still owed by the block
class lcg_byte_predictor;
  localparam int unsigned MaxReadBytes = 64;

  logic [63:0]     lcg_state;
  logic            seeded;
  logic [63:0]     cfg_seed;
  lcgrb_pkg::out_t pending_bytes[$];
  int unsigned     mismatches;

  function new();
    lcg_state  = '0;
    seeded     = 1'b0;
    cfg_seed   = lcgrb_pkg::SeedReset;
    mismatches = 0;
  endfunction

  // One LCG step, then the fmix64 finalizer; keeps the upper half
  function logic [31:0] next_word();
    logic [63:0] x;
    lcg_state = lcgrb_pkg::LcgMul * lcg_state + lcgrb_pkg::LcgAdd;
    x = lcg_state;
    x = x ^ (x >> lcgrb_pkg::FmixShift);
    x = x * lcgrb_pkg::FmixK1;
    x = x ^ (x >> lcgrb_pkg::FmixShift);
    x = x * lcgrb_pkg::FmixK2;
    x = x ^ (x >> lcgrb_pkg::FmixShift);
    return x[63:32];
  endfunction

  // Called for every accepted request beat
  function void note_request(lcgrb_pkg::in_t req);
    int unsigned     n;
    logic [31:0]     word;
    lcgrb_pkg::out_t b;
    word = '0;
    if (req.command == lcgrb_pkg::CmdSeed) begin
      lcg_state = req.seed_value;
      seeded    = 1'b1;
      return;
    end
    n = (req.read_length > MaxReadBytes) ? MaxReadBytes : req.read_length;
    if (n == 0) return;
    if (!seeded) begin
      lcg_state = cfg_seed;
      seeded    = 1'b1;
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 4 == 0) word = next_word();
      b.random_byte = word[7:0];
      b.last_byte   = (i + 1 == n);
      pending_bytes.push_back(b);
      word = word >> 8;
    end
  endfunction

  // Called for every accepted result beat
  function void check_byte(lcgrb_pkg::out_t got);
    lcgrb_pkg::out_t want;
    if (pending_bytes.size() == 0) begin
      $error("unexpected result beat: random_byte %h last_byte %b",
             got.random_byte, got.last_byte);
      mismatches++;
      return;
    end
    want = pending_bytes.pop_front();
    if (got.random_byte !== want.random_byte) begin
      $error("random_byte: expected %h, got %h", want.random_byte, got.random_byte);
      mismatches++;
    end
    if (got.last_byte !== want.last_byte) begin
      $error("last_byte: expected %b, got %b", want.last_byte, got.last_byte);
      mismatches++;
    end
  endfunction
endclass

module tb_lcg_mixed_random_byte_source;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned DrainCycles = 64;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  lcgrb_pkg::in_t  in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  lcgrb_pkg::out_t out_data_o;
  logic            cfg_we_i;
  logic [63:0]     cfg_wdata_i;

  lcg_byte_predictor predictor = new();
  logic              no_idle = 1'b0;
  int unsigned       cycle_count = 0;

  lcg_mixed_random_byte_source #(
    .MAX_READ_BYTES(64)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10-unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none in calm stretches
  function automatic int unsigned idle_len();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lcgrb_pkg::in_t make_req(logic cmd, logic [63:0] seed,
                                              logic [6:0] len);
    lcgrb_pkg::in_t r;
    r.command     = cmd;
    r.seed_value  = seed;
    r.read_length = len;
    return r;
  endfunction

  // Random request: mostly short reads, some seeds, empty and overlong reads
  function automatic lcgrb_pkg::in_t rand_req();
    lcgrb_pkg::in_t r;
    int unsigned    p;
    r.command     = lcgrb_pkg::CmdRead;
    r.seed_value  = {$urandom, $urandom};
    r.read_length = 7'($urandom_range(1, 16));
    p = $urandom_range(0, 99);
    if (p < 15) begin
      r.command     = lcgrb_pkg::CmdSeed;
      r.read_length = 7'($urandom_range(0, 127));
    end else if (p < 20) begin
      r.read_length = 7'd0;
    end else if (p < 27) begin
      r.read_length = 7'($urandom_range(65, 127));
    end else if (p < 32) begin
      r.read_length = 7'($urandom_range(33, 64));
    end
    return r;
  endfunction

  // Present one request beat and wait for it to be taken; valid stays high
  task automatic send_request(input lcgrb_pkg::in_t req);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predictor.note_request(req);
  endtask

  // Drop valid after the last beat, then let every owed byte come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (predictor.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_power_on_seed(input logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    predictor.cfg_seed = value;
  endtask

  task automatic random_phase(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) send_request(rand_req());
    drain();
  endtask

  // Result sink: checks accepted beats and stalls ready at random
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) predictor.check_byte(out_data_o);
      if (stall_left == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First read runs unseeded, so it starts from this register value
    write_power_on_seed(64'h0);

    // Directed: size extremes, seeds, empty and overlong reads
    send_request(make_req(lcgrb_pkg::CmdRead, '1, 7'd5));
    send_request(make_req(lcgrb_pkg::CmdRead, '1, 7'd0));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd1));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd4));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd127));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd65));
    send_request(make_req(lcgrb_pkg::CmdSeed, '0, 7'd127));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd64));
    send_request(make_req(lcgrb_pkg::CmdSeed, '1, 7'd0));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd63));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd2));
    send_request(make_req(lcgrb_pkg::CmdSeed, {$urandom, $urandom}, 7'd5));
    send_request(make_req(lcgrb_pkg::CmdSeed, {$urandom, $urandom}, 7'd0));
    send_request(make_req(lcgrb_pkg::CmdRead, '1, 7'd3));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd0));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd7));
    send_request(make_req(lcgrb_pkg::CmdRead, '1, 7'd8));
    send_request(make_req(lcgrb_pkg::CmdRead, '0, 7'd9));
    drain();

    // Random traffic under several register settings
    write_power_on_seed('1);
    random_phase(130);

    write_power_on_seed({$urandom, $urandom});
    no_idle = 1'b1;
    random_phase(100);

    no_idle = 1'b0;
    write_power_on_seed(lcgrb_pkg::SeedReset);
    random_phase(150);

    if (predictor.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/lcgrb_pkg.sv
rtl/lcg_mixed_random_byte_source.sv
bench/tb_lcg_mixed_random_byte_source.sv
